@@ src/huffman_code_bit_packer_unit_assert.svh @@
// Assertion macros shared by the bit packer RTL.
`ifndef HUFFMAN_CODE_BIT_PACKER_UNIT_ASSERT_SVH
`define HUFFMAN_CODE_BIT_PACKER_UNIT_ASSERT_SVH

// Antecedent in a cycle implies the consequent in the same cycle.
`define HCBP_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent in a cycle implies the consequent in the next cycle.
`define HCBP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/hcbp_pkg.sv @@
// Types and constants of the Huffman code bit packer.
`timescale 1ns / 1ps

package hcbp_pkg;

    localparam int CODE_W     = 32;
    localparam int LEN_W      = 6;
    localparam int SYM_W      = 8;
    localparam int ACT_W      = 2;
    localparam int BYTE_W     = 8;
    localparam int WIN_W      = 40;
    localparam int BUF_W      = 32;
    localparam int CNT_W      = 3;
    localparam int TOTAL_W    = 7;

    typedef enum logic [ACT_W-1:0] {
        ACT_LOAD   = 2'd0,
        ACT_ENCODE = 2'd1,
        ACT_FLUSH  = 2'd2
    } action_t;

    typedef struct packed {
        logic [LEN_W-1:0]  len;
        logic [CODE_W-1:0] code;
    } tab_entry_t;

endpackage

@@ src/hcbp_if.sv @@
// Valid/ready channel interfaces for symbols in and packed bytes out.
`timescale 1ns / 1ps

interface hcbp_sym_if;
    logic                           valid;
    logic                           ready;
    logic [hcbp_pkg::ACT_W-1:0]     action;
    logic [hcbp_pkg::SYM_W-1:0]     symbol;
    logic [hcbp_pkg::CODE_W-1:0]    code_bits;
    logic [hcbp_pkg::LEN_W-1:0]     code_length;

    modport source (output valid, action, symbol, code_bits, code_length, input ready);
    modport sink (input valid, action, symbol, code_bits, code_length, output ready);
endinterface

interface hcbp_byte_if;
    logic                           valid;
    logic                           ready;
    logic [hcbp_pkg::BYTE_W-1:0]    byte_out;
    logic                           last_of_run;

    modport source (output valid, byte_out, last_of_run, input ready);
    modport sink (input valid, byte_out, last_of_run, output ready);
endinterface

@@ src/hcbp_table.sv @@
// Code table memory with per-entry valid bits for the code length.
`timescale 1ns / 1ps

module hcbp_table #(
    parameter int SYMBOL_COUNT = 256,
    parameter int ADDR_W       = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_en,
    input  logic                 rd_en,
    input  logic [ADDR_W-1:0]    addr,
    input  hcbp_pkg::tab_entry_t wr_entry,
    output hcbp_pkg::tab_entry_t rd_entry
);

    hcbp_pkg::tab_entry_t tab_mem [SYMBOL_COUNT];
    hcbp_pkg::tab_entry_t rd_data_reg;
    logic                 rd_valid_reg;
    logic [SYMBOL_COUNT-1:0] vld_reg;

    // Valid bits stand in for the all-zero reset of the length column.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (wr_en)
        begin
            vld_reg[addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            tab_mem[addr] <= wr_entry;
        end
        if (rd_en)
        begin
            rd_data_reg  <= tab_mem[addr];
            rd_valid_reg <= vld_reg[addr];
        end
    end

    always_comb
    begin
        rd_entry      = rd_data_reg;
        rd_entry.len  = rd_valid_reg ? rd_data_reg.len : '0;
    end

endmodule

@@ src/huffman_code_bit_packer_unit.sv @@
// Huffman code bit packer: code table lookup and MSB-first byte packing.
// Bytes pass from the lookup stage through the emit buffer into the output register.
// Throughput: one item per cycle while each causes at most one byte and the output takes
// its bytes; an item that makes k bytes holds the next byte-making item until all k are sent.
// Reset clears the accumulator, the pipeline and the length valid bits at once;
// code words are undefined until loaded and need no clearing pass.
`timescale 1ns / 1ps

module huffman_code_bit_packer_unit #(
    parameter int SYMBOL_COUNT  = 256,
    parameter int MAX_CODE_BITS = 32
) (
    input  logic         clk,
    input  logic         rst_n,
    hcbp_sym_if.sink     symbols,
    hcbp_byte_if.source  stream
);

    `include "huffman_code_bit_packer_unit_assert.svh"

    localparam int ADDR_W    = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
    localparam int LEN_LIMIT = (MAX_CODE_BITS < hcbp_pkg::CODE_W) ? MAX_CODE_BITS
                                                                  : hcbp_pkg::CODE_W;

    // Input acceptance and table access.
    logic                 accept;
    logic                 in_range;
    logic                 tab_wr_en;
    logic                 tab_rd_en;
    hcbp_pkg::tab_entry_t wr_entry;
    hcbp_pkg::tab_entry_t rd_entry;

    // Lookup stage.
    logic                       s1_valid_reg;
    logic [hcbp_pkg::ACT_W-1:0] s1_act_reg;
    logic                       s1_in_range_reg;
    logic                       s1_go;

    // Packer state.
    logic [hcbp_pkg::BYTE_W-1:0] acc_reg;
    logic [2:0]                  pend_reg;
    logic [hcbp_pkg::BYTE_W-1:0] acc_next;
    logic [2:0]                  pend_next;

    // Packing datapath.
    logic [hcbp_pkg::LEN_W-1:0]   eff_len;
    logic [hcbp_pkg::CODE_W:0]    len_mask;
    logic [hcbp_pkg::CODE_W-1:0]  code_m;
    logic [hcbp_pkg::TOTAL_W-1:0] total;
    logic [hcbp_pkg::TOTAL_W-1:0] shamt;
    logic [hcbp_pkg::WIN_W-1:0]   win;
    logic [hcbp_pkg::CNT_W-1:0]   nb;
    logic [hcbp_pkg::BUF_W-1:0]   bytes_new;

    // Emit stage and output register.
    logic [hcbp_pkg::BUF_W-1:0]  buf_reg;
    logic [hcbp_pkg::CNT_W-1:0]  cnt_reg;
    logic                        push;
    logic                        s2_free;
    logic                        ov_reg;
    logic [hcbp_pkg::BYTE_W-1:0] ob_reg;
    logic                        last_reg;

    assign in_range  = ({1'b0, symbols.symbol} < (hcbp_pkg::SYM_W + 1)'(SYMBOL_COUNT));
    assign accept    = symbols.valid && symbols.ready;
    assign tab_wr_en = accept && in_range && (symbols.action == hcbp_pkg::ACT_LOAD);
    assign tab_rd_en = accept && in_range && (symbols.action == hcbp_pkg::ACT_ENCODE);

    always_comb
    begin
        wr_entry.code = symbols.code_bits;
        wr_entry.len  = (symbols.code_length > hcbp_pkg::LEN_W'(LEN_LIMIT))
                        ? hcbp_pkg::LEN_W'(LEN_LIMIT) : symbols.code_length;
    end

    // A load writes at its own accept edge and an encode reads at its own, so
    // accesses to one entry never overlap and no forwarding is needed.
    hcbp_table #(
        .SYMBOL_COUNT (SYMBOL_COUNT),
        .ADDR_W       (ADDR_W)
    ) u_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (tab_wr_en),
        .rd_en    (tab_rd_en),
        .addr     (symbols.symbol[ADDR_W-1:0]),
        .wr_entry (wr_entry),
        .rd_entry (rd_entry)
    );

    // Place the pending bits and the masked code word in one 40-bit window,
    // then cut whole bytes off the top.
    always_comb
    begin
        eff_len   = (s1_act_reg == hcbp_pkg::ACT_ENCODE && s1_in_range_reg) ? rd_entry.len : '0;
        len_mask  = ((hcbp_pkg::CODE_W + 1)'(1) << eff_len) - (hcbp_pkg::CODE_W + 1)'(1);
        code_m    = rd_entry.code & len_mask[hcbp_pkg::CODE_W-1:0];
        total     = hcbp_pkg::TOTAL_W'(pend_reg) + hcbp_pkg::TOTAL_W'(eff_len);
        shamt     = hcbp_pkg::TOTAL_W'(hcbp_pkg::WIN_W) - total;
        win       = {acc_reg, {hcbp_pkg::BUF_W{1'b0}}}
                  | (hcbp_pkg::WIN_W'(code_m) << shamt);
        nb        = '0;
        bytes_new = win[hcbp_pkg::WIN_W-1:hcbp_pkg::BYTE_W];
        acc_next  = acc_reg;
        pend_next = pend_reg;
        unique case (s1_act_reg)
            hcbp_pkg::ACT_ENCODE:
            begin
                nb        = total[5:3];
                acc_next  = hcbp_pkg::BYTE_W'(win >> (6'd32 - {nb, 3'b000}));
                pend_next = total[2:0];
            end
            hcbp_pkg::ACT_FLUSH:
            begin
                nb        = (pend_reg != 3'd0) ? hcbp_pkg::CNT_W'(1) : '0;
                bytes_new = {acc_reg, {(hcbp_pkg::BUF_W - hcbp_pkg::BYTE_W){1'b0}}};
                acc_next  = '0;
                pend_next = '0;
            end
            default:
            begin
                nb = '0;
            end
        endcase
    end

    assign push    = (cnt_reg != '0) && (!ov_reg || stream.ready);
    assign s2_free = (cnt_reg == '0) || ((cnt_reg == hcbp_pkg::CNT_W'(1)) && push);
    assign s1_go   = !s1_valid_reg || (nb == '0) || s2_free;
    assign symbols.ready = s1_go;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            s1_act_reg      <= hcbp_pkg::ACT_LOAD;
            s1_in_range_reg <= 1'b0;
            acc_reg         <= '0;
            pend_reg        <= '0;
            cnt_reg         <= '0;
            ov_reg          <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg    <= 1'b1;
                s1_act_reg      <= symbols.action;
                s1_in_range_reg <= in_range;
            end
            else if (s1_go)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_valid_reg && s1_go)
            begin
                acc_reg  <= acc_next;
                pend_reg <= pend_next;
            end

            if (s1_valid_reg && s1_go && (nb != '0))
            begin
                cnt_reg <= nb;
            end
            else if (push)
            begin
                cnt_reg <= cnt_reg - hcbp_pkg::CNT_W'(1);
            end

            if (push)
            begin
                ov_reg <= 1'b1;
            end
            else if (stream.ready)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg && s1_go && (nb != '0))
        begin
            buf_reg <= bytes_new;
        end
        else if (push)
        begin
            buf_reg <= buf_reg << hcbp_pkg::BYTE_W;
        end

        if (push)
        begin
            ob_reg   <= buf_reg[hcbp_pkg::BUF_W-1 -: hcbp_pkg::BYTE_W];
            last_reg <= (cnt_reg == hcbp_pkg::CNT_W'(1));
        end
    end

    assign stream.valid       = ov_reg;
    assign stream.byte_out    = ob_reg;
    assign stream.last_of_run = last_reg;

    `HCBP_ASSERT_SAME(a_cnt_bound, clk, rst_n, 1'b1, cnt_reg <= hcbp_pkg::CNT_W'(4),
        "emit count exceeds four bytes")
    `HCBP_ASSERT_SAME(a_acc_clean, clk, rst_n, pend_reg == 3'd0, acc_reg == '0,
        "accumulator holds bits with nothing pending")
    `HCBP_ASSERT_SAME(a_stall_blocks, clk, rst_n, s1_valid_reg && (nb != '0) && !s2_free,
        !symbols.ready, "input taken while the emit stage is busy")
    `HCBP_ASSERT_NEXT(a_push_shows, clk, rst_n, push, stream.valid,
        "byte moved to the output register but not shown")

endmodule

@@ bench/huffman_code_bit_packer_unit_test.sv @@
// Self-checking bench for the Huffman code bit packer: table loads, encodes, flushes and unknown actions.
`timescale 1ns / 1ps

module huffman_code_bit_packer_unit_test;

    import hcbp_pkg::*;

    localparam int          LEN_CAP     = CODE_W;   // stored lengths saturate here
    localparam int          SYMS        = 256;
    localparam int          RANDOM_ITEMS = 460;
    localparam int          CYCLE_LIMIT = 200000;
    localparam int          DRAIN_CYCLES = 20;
    localparam int          HOLD_START  = 200;
    localparam int          HOLD_CYCLES = 300;
    localparam logic [ACT_W-1:0] ACT_UNKNOWN = 2'd3;

    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic [SYM_W-1:0]  symbol;
        logic [CODE_W-1:0] code_bits;
        logic [LEN_W-1:0]  code_length;
    } sym_item_t;

    typedef struct packed {
        logic [BYTE_W-1:0] value;
        logic              last;
    } packed_byte_t;

    logic clk;
    logic rst_n;

    hcbp_sym_if  symbols ();
    hcbp_byte_if stream ();

    huffman_code_bit_packer_unit u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .symbols (symbols.sink),
        .stream  (stream.source)
    );

    // Predictor state.
    logic [CODE_W-1:0] code_word [SYMS];
    logic [LEN_W-1:0]  code_len  [SYMS];
    logic [BYTE_W-1:0] acc_byte;
    int                acc_fill;

    sym_item_t    pending_items [$];
    packed_byte_t expected_bytes [$];
    int           loaded_syms [$];
    bit           sym_loaded [SYMS];

    int mismatches;
    int cycle_count;
    int burst_left;
    int gap_left;
    int recv_cycles;
    int hold_left;
    int stall_mode;

    // Applies one accepted item to the predictor and queues the bytes it makes.
    function automatic void pack_symbol(input sym_item_t it);
        packed_byte_t made [$];
        packed_byte_t b;
        int           n;
        logic [CODE_W-1:0] code;
        case (it.action)
            ACT_LOAD:
            begin
                code_word[it.symbol] = it.code_bits;
                code_len[it.symbol]  = (it.code_length > LEN_CAP) ? LEN_W'(LEN_CAP)
                                                                  : it.code_length;
            end
            ACT_ENCODE:
            begin
                n    = code_len[it.symbol];
                code = code_word[it.symbol];
                while (n > 0)
                begin
                    n--;
                    acc_byte[7 - acc_fill] = code[n];
                    acc_fill++;
                    if (acc_fill == 8)
                    begin
                        b.value = acc_byte;
                        b.last  = 1'b0;
                        made.push_back(b);
                        acc_byte = '0;
                        acc_fill = 0;
                    end
                end
            end
            ACT_FLUSH:
            begin
                if (acc_fill != 0)
                begin
                    b.value = acc_byte;
                    b.last  = 1'b0;
                    made.push_back(b);
                    acc_byte = '0;
                    acc_fill = 0;
                end
            end
            default:
            begin
            end
        endcase
        if (made.size() > 0)
            made[made.size() - 1].last = 1'b1;
        foreach (made[i])
            expected_bytes.push_back(made[i]);
    endfunction

    function automatic void add_item(input logic [ACT_W-1:0] act, input int sym,
                                     input logic [CODE_W-1:0] bits, input int len);
        sym_item_t it;
        it.action      = act;
        it.symbol      = SYM_W'(sym);
        it.code_bits   = bits;
        it.code_length = LEN_W'(len);
        if (act == ACT_LOAD && !sym_loaded[sym])
        begin
            sym_loaded[sym] = 1'b1;
            loaded_syms.push_back(sym);
        end
        pending_items.push_back(it);
    endfunction

    function automatic int random_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)
            return 0;
        else if (r < 75)
            return $urandom_range(1, 12);
        else if (r < 92)
            return $urandom_range(13, 32);
        return $urandom_range(33, 63);
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Sender: bursts of random length separated by random gaps.
    always @(posedge clk or negedge rst_n)
    begin
        sym_item_t it;
        logic      offer;
        if (!rst_n)
        begin
            symbols.valid       <= 1'b0;
            symbols.action      <= ACT_LOAD;
            symbols.symbol      <= '0;
            symbols.code_bits   <= '0;
            symbols.code_length <= '0;
        end
        else
        begin
            if (symbols.valid && symbols.ready)
            begin
                it.action      = symbols.action;
                it.symbol      = symbols.symbol;
                it.code_bits   = symbols.code_bits;
                it.code_length = symbols.code_length;
                pack_symbol(it);
            end
            if (!symbols.valid || symbols.ready)
            begin
                offer = 1'b0;
                if (gap_left > 0)
                    gap_left--;
                else if (pending_items.size() > 0)
                begin
                    it    = pending_items.pop_front();
                    offer = 1'b1;
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        burst_left = $urandom_range(1, 40);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end
                end
                symbols.valid <= offer;
                if (offer)
                begin
                    symbols.action      <= it.action;
                    symbols.symbol      <= it.symbol;
                    symbols.code_bits   <= it.code_bits;
                    symbols.code_length <= it.code_length;
                end
            end
        end
    end

    // Receiver: switches among random stall patterns, and once it holds off
    // long enough for the block to back up into its input.
    always @(posedge clk or negedge rst_n)
    begin
        logic take;
        if (!rst_n)
            stream.ready <= 1'b0;
        else
        begin
            recv_cycles++;
            if (recv_cycles % 64 == 0)
                stall_mode = $urandom_range(0, 3);
            if (recv_cycles == HOLD_START)
                hold_left = HOLD_CYCLES;
            if (hold_left > 0)
            begin
                hold_left--;
                take = 1'b0;
            end
            else
            begin
                case (stall_mode)
                    0:       take = 1'b1;
                    1:       take = 1'($urandom_range(0, 1));
                    2:       take = ($urandom_range(0, 3) == 0);
                    default: take = (recv_cycles % 8) < 5;
                endcase
            end
            stream.ready <= take;
        end
    end

    always @(posedge clk)
    begin
        packed_byte_t want;
        if (rst_n && stream.valid && stream.ready)
        begin
            if (expected_bytes.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected byte: byte_out=%02h last_of_run=%0b",
                             stream.byte_out, stream.last_of_run);
            end
            else
            begin
                want = expected_bytes.pop_front();
                if (stream.byte_out !== want.value || stream.last_of_run !== want.last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("byte mismatch: expected %02h/%0b, got %02h/%0b",
                                 want.value, want.last, stream.byte_out,
                                 stream.last_of_run);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        int r;
        int pick;
        rst_n       = 1'b0;
        mismatches  = 0;
        cycle_count = 0;
        burst_left  = $urandom_range(1, 40);
        gap_left    = 0;
        recv_cycles = 0;
        hold_left   = 0;
        stall_mode  = 0;
        acc_byte    = '0;
        acc_fill    = 0;
        foreach (code_len[i])
        begin
            code_len[i]   = '0;
            code_word[i]  = '0;
            sym_loaded[i] = 1'b0;
        end

        // Directed part: field extremes, saturation, unused symbols, aligned flushes.
        add_item(ACT_LOAD, 8'h00, 32'h0000_0000, 1);
        add_item(ACT_LOAD, 8'hFF, 32'hFFFF_FFFF, 32);
        add_item(ACT_LOAD, 8'h5A, 32'hA5A5_A5A5, 63);
        add_item(ACT_LOAD, 8'h81, $urandom(), 0);
        add_item(ACT_LOAD, 8'h3C, 32'hFFFF_FFF5, 3);
        add_item(ACT_LOAD, 8'h7E, 32'h1234_56C3, 8);
        add_item(ACT_FLUSH, 8'h00, 32'h0, 0);
        add_item(ACT_ENCODE, 8'h81, 32'h0, 0);
        add_item(ACT_ENCODE, 8'h00, 32'hFFFF_FFFF, 63);
        add_item(ACT_ENCODE, 8'hFF, 32'h0, 0);
        add_item(ACT_ENCODE, 8'h5A, 32'h0, 0);
        add_item(ACT_ENCODE, 8'h3C, 32'h0, 0);
        add_item(ACT_FLUSH, 8'hFF, 32'hFFFF_FFFF, 63);
        add_item(ACT_FLUSH, 8'h00, 32'h0, 0);
        add_item(ACT_UNKNOWN, 8'hFF, 32'hFFFF_FFFF, 63);
        add_item(ACT_ENCODE, 8'h7E, 32'h0, 0);
        add_item(ACT_ENCODE, 8'hFF, 32'h0, 0);
        add_item(ACT_FLUSH, 8'h00, 32'h0, 0);
        add_item(ACT_ENCODE, 8'h3C, 32'h0, 0);
        add_item(ACT_UNKNOWN, 8'h00, 32'h0, 0);
        add_item(ACT_FLUSH, 8'h00, 32'h0, 0);

        // Random part: mostly encodes of loaded symbols, with loads, flushes and unknown actions.
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 15)
                add_item(ACT_LOAD, $urandom_range(0, SYMS - 1), $urandom(), random_length());
            else if (r < 85)
            begin
                pick = loaded_syms[$urandom_range(0, loaded_syms.size() - 1)];
                add_item(ACT_ENCODE, pick, $urandom(), $urandom_range(0, 63));
            end
            else if (r < 95)
                add_item(ACT_FLUSH, $urandom_range(0, SYMS - 1), $urandom(),
                         $urandom_range(0, 63));
            else
                add_item(ACT_UNKNOWN, $urandom_range(0, SYMS - 1), $urandom(),
                         $urandom_range(0, 63));
        end
        add_item(ACT_FLUSH, 8'h00, 32'h0, 0);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_items.size() != 0 || symbols.valid)
            @(posedge clk);
        while (expected_bytes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && expected_bytes.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
